### design/cha_pkg.sv
// Shared constants and the arctangent table for the compass heading pipeline.
// Used by every module of the block; depends on nothing.
package cha_pkg;

  // Default configuration of the top level.
  localparam int unsigned INPUT_WIDTH_DEF  = 18;
  localparam int unsigned ANGLE_STAGES_DEF = 16;

  // Number of arctangent table entries; the stage count may not exceed it.
  localparam int unsigned TABLE_LEN = 24;

  // Fraction bits appended to the field components before rotation.
  localparam int unsigned GUARD_BITS = 24;

  // Headroom over the input width: fold negation, the sqrt(2) of the
  // diagonal, and the rotation gain, plus the sign bit.
  localparam int unsigned VEC_HEADROOM = 3;

  // Accumulated angle: signed, in units of 2^-16 degree, range about
  // -100 to +280 degrees.
  localparam int unsigned ANG_W = 26;

  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;

  // The output keeps 6 fraction bits of the 16 in the angle.
  localparam int unsigned ROUND_SHIFT = 10;
  localparam logic [ANG_W-1:0] ROUND_HALF = 26'd512;

  localparam int unsigned HEADING_W = 15;
  localparam int unsigned HRAW_W    = ANG_W - ROUND_SHIFT;
  localparam logic [HRAW_W-1:0] FULL_TURN_OUT = 16'd23040;

  // atan(2^-idx) in degrees times 65536, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      0:       val = 26'sd2949120;
      1:       val = 26'sd1740967;
      2:       val = 26'sd919879;
      3:       val = 26'sd466945;
      4:       val = 26'sd234379;
      5:       val = 26'sd117304;
      6:       val = 26'sd58666;
      7:       val = 26'sd29335;
      8:       val = 26'sd14668;
      9:       val = 26'sd7334;
      10:      val = 26'sd3667;
      11:      val = 26'sd1833;
      12:      val = 26'sd917;
      13:      val = 26'sd458;
      14:      val = 26'sd229;
      15:      val = 26'sd115;
      16:      val = 26'sd57;
      17:      val = 26'sd29;
      18:      val = 26'sd14;
      19:      val = 26'sd7;
      20:      val = 26'sd4;
      21:      val = 26'sd2;
      22:      val = 26'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### design/compass_heading_atan2.sv
// Compass heading top level: input fold, a chain of CORDIC rotation cells and
// the output rounding stage. Depends on cha_pkg, cha_fold, cha_cell, cha_out.
//
// Takes a signed field pair (x, y) and returns atan2(y, x) in 1/64 degree,
// 0 to 23039; a zero vector gives 0. One request is accepted every clock
// cycle while the output is not stalled; each result passes through the fold
// register, one register per rotation cell and the output register. Every stage
// has its own valid bit and moves on whenever the next stage is free, so a
// stalled output only holds back stages that are already full.
module compass_heading_atan2 #(
  parameter int unsigned INPUT_WIDTH  = cha_pkg::INPUT_WIDTH_DEF,
  parameter int unsigned ANGLE_STAGES = cha_pkg::ANGLE_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [INPUT_WIDTH-1:0]     field_x_i,
  input  logic signed [INPUT_WIDTH-1:0]     field_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cha_pkg::HEADING_W-1:0]     heading_o
);

  localparam int unsigned VecW = INPUT_WIDTH + cha_pkg::GUARD_BITS + cha_pkg::VEC_HEADROOM;

  logic                             valid [ANGLE_STAGES+1];
  logic                             ready [ANGLE_STAGES+1];
  logic signed [VecW-1:0]           x     [ANGLE_STAGES+1];
  logic signed [VecW-1:0]           y     [ANGLE_STAGES+1];
  logic signed [cha_pkg::ANG_W-1:0] ang   [ANGLE_STAGES+1];
  logic                             zero  [ANGLE_STAGES+1];

  cha_fold #(
    .INPUT_WIDTH (INPUT_WIDTH),
    .VEC_W       (VecW)
  ) u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .field_x_i (field_x_i),
    .field_y_i (field_y_i),
    .valid_o   (valid[0]),
    .ready_i   (ready[0]),
    .x_o       (x[0]),
    .y_o       (y[0]),
    .ang_o     (ang[0]),
    .zero_o    (zero[0])
  );

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
    cha_cell #(
      .STAGE (k),
      .VEC_W (VecW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .x_i     (x[k]),
      .y_i     (y[k]),
      .ang_i   (ang[k]),
      .zero_i  (zero[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .x_o     (x[k+1]),
      .y_o     (y[k+1]),
      .ang_o   (ang[k+1]),
      .zero_o  (zero[k+1])
    );
  end

  cha_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid[ANGLE_STAGES]),
    .ready_o   (ready[ANGLE_STAGES]),
    .ang_i     (ang[ANGLE_STAGES]),
    .zero_i    (zero[ANGLE_STAGES]),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .heading_o (heading_o)
  );

endmodule

### design/cha_fold.sv
// Input stage: sign extension, half-plane fold and guard-bit scaling.
// Depends on cha_pkg.
module cha_fold #(
  parameter int unsigned INPUT_WIDTH = cha_pkg::INPUT_WIDTH_DEF,
  parameter int unsigned VEC_W = INPUT_WIDTH + cha_pkg::GUARD_BITS + cha_pkg::VEC_HEADROOM
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [INPUT_WIDTH-1:0]       field_x_i,
  input  logic signed [INPUT_WIDTH-1:0]       field_y_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [VEC_W-1:0]             x_o,
  output logic signed [VEC_W-1:0]             y_o,
  output logic signed [cha_pkg::ANG_W-1:0]    ang_o,
  output logic                                zero_o
);

  logic                             valid_q;
  logic                             load;
  logic signed [VEC_W-1:0]          x_ext, y_ext, x_sc, y_sc;
  logic signed [VEC_W-1:0]          x_d, y_d, x_q, y_q;
  logic signed [cha_pkg::ANG_W-1:0] ang_d, ang_q;
  logic                             zero_d, zero_q;
  logic                             neg;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    x_ext  = {{(VEC_W-INPUT_WIDTH){field_x_i[INPUT_WIDTH-1]}}, field_x_i};
    y_ext  = {{(VEC_W-INPUT_WIDTH){field_y_i[INPUT_WIDTH-1]}}, field_y_i};
    x_sc   = x_ext <<< cha_pkg::GUARD_BITS;
    y_sc   = y_ext <<< cha_pkg::GUARD_BITS;
    neg    = field_x_i[INPUT_WIDTH-1];
    // A vector in the left half-plane is turned by 180 degrees.
    x_d    = neg ? -x_sc : x_sc;
    y_d    = neg ? -y_sc : y_sc;
    ang_d  = neg ? cha_pkg::DEG180 : '0;
    zero_d = (field_x_i == '0) && (field_y_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= x_d;
      y_q    <= y_d;
      ang_q  <= ang_d;
      zero_q <= zero_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;
  assign zero_o  = zero_q;

endmodule

### design/cha_cell.sv
// One vectoring rotation cell: turns the vector toward the x axis by
// atan(2^-STAGE) and books the angle. Depends on cha_pkg.
module cha_cell #(
  parameter int unsigned STAGE = 0,
  parameter int unsigned VEC_W = cha_pkg::INPUT_WIDTH_DEF + cha_pkg::GUARD_BITS
                                 + cha_pkg::VEC_HEADROOM
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [VEC_W-1:0]          x_i,
  input  logic signed [VEC_W-1:0]          y_i,
  input  logic signed [cha_pkg::ANG_W-1:0] ang_i,
  input  logic                             zero_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [VEC_W-1:0]          x_o,
  output logic signed [VEC_W-1:0]          y_o,
  output logic signed [cha_pkg::ANG_W-1:0] ang_o,
  output logic                             zero_o
);

  localparam logic signed [cha_pkg::ANG_W-1:0] AtanStep = cha_pkg::atan_entry(STAGE);

  logic                             valid_q;
  logic                             load;
  logic signed [VEC_W-1:0]          xs, ys;
  logic signed [VEC_W-1:0]          x_d, y_d, x_q, y_q;
  logic signed [cha_pkg::ANG_W-1:0] ang_d, ang_q;
  logic                             zero_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    // Arithmetic shifts round toward minus infinity.
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[VEC_W-1]) begin
      x_d   = x_i + ys;
      y_d   = y_i - xs;
      ang_d = ang_i + AtanStep;
    end else begin
      x_d   = x_i - ys;
      y_d   = y_i + xs;
      ang_d = ang_i - AtanStep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= x_d;
      y_q    <= y_d;
      ang_q  <= ang_d;
      zero_q <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;
  assign zero_o  = zero_q;

endmodule

### design/cha_out.sv
// Output stage: folds the angle into one turn, rounds to 1/64 degree and
// holds the heading for the downstream side. Depends on cha_pkg.
module cha_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [cha_pkg::ANG_W-1:0]   ang_i,
  input  logic                               zero_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [cha_pkg::HEADING_W-1:0]      heading_o
);

  logic                              valid_q;
  logic                              load;
  logic [cha_pkg::ANG_W-1:0]         ang_pos, ang_rnd;
  logic [cha_pkg::HRAW_W-1:0]        h_raw, h_wrap;
  logic [cha_pkg::HEADING_W-1:0]     heading_d, heading_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    ang_pos = ang_i[cha_pkg::ANG_W-1] ? unsigned'(ang_i + cha_pkg::DEG360)
                                      : unsigned'(ang_i);
    ang_rnd = ang_pos + cha_pkg::ROUND_HALF;
    h_raw   = ang_rnd[cha_pkg::ANG_W-1:cha_pkg::ROUND_SHIFT];
    // A heading that rounds up to a full turn reads as zero.
    h_wrap  = (h_raw >= cha_pkg::FULL_TURN_OUT) ? h_raw - cha_pkg::FULL_TURN_OUT : h_raw;
    heading_d = zero_i ? '0 : h_wrap[cha_pkg::HEADING_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;

endmodule

### tb/tb_top.sv
// Testbench for compass_heading_atan2: random and directed field pairs, a
// bit-exact heading predictor and an in-order checker on the result channel.
// Depends on cha_pkg and the compass_heading_atan2 design files.
module tb_top;

  localparam int unsigned W       = cha_pkg::INPUT_WIDTH_DEF;
  localparam int unsigned STAGES  = cha_pkg::ANGLE_STAGES_DEF;
  localparam int unsigned HW      = cha_pkg::HEADING_W;
  localparam int unsigned ANGLES  = 24;
  localparam int unsigned FRAC    = 24;
  localparam int unsigned N_RAND  = 1050;

  // Angles in units of 2^-16 degree; FULL_TURN_OUT in 1/64 degree.
  localparam longint HALF_TURN_Q16 = 64'sd11796480;
  localparam longint FULL_TURN_Q16 = 64'sd23592960;
  localparam longint FULL_TURN_OUT = 64'sd23040;

  localparam int ATAN_Q16 [ANGLES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam logic signed [W-1:0] F_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] F_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
  } field_pair_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready_o;
  logic signed [W-1:0] field_x     = '0;
  logic signed [W-1:0] field_y     = '0;
  logic                out_valid_o;
  logic                out_ready   = 1'b0;
  logic [HW-1:0]       heading_o;

  field_pair_t   pending_pairs[$];
  logic [HW-1:0] headings_due[$];
  int            gap_left    = 0;
  int            stall_left  = 0;
  int            n_sent      = 0;
  int            n_errors    = 0;
  logic          hold_on     = 1'b0;
  logic          hold_done   = 1'b0;
  int            hold_cnt    = 0;

  compass_heading_atan2 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .field_x_i   (field_x),
    .field_y_i   (field_y),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .heading_o   (heading_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Vectoring CORDIC heading, folded into [0, 360) degrees in 1/64 degree.
  function automatic logic [HW-1:0] heading_of(logic signed [W-1:0] fx,
                                               logic signed [W-1:0] fy);
    longint vx;
    longint vy;
    longint sx;
    longint sy;
    longint ang;
    longint h;
    vx  = fx;
    vy  = fy;
    ang = 0;
    if (vx == 0 && vy == 0) return '0;
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      ang = HALF_TURN_Q16;
    end
    vx = vx <<< FRAC;
    vy = vy <<< FRAC;
    for (int i = 0; i < STAGES && i < ANGLES; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        ang = ang + ATAN_Q16[i];
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        ang = ang - ATAN_Q16[i];
      end
    end
    if (ang < 0) ang = ang + FULL_TURN_Q16;
    h = (ang + 512) >>> 10;
    // A heading that rounds up to a full turn reads zero.
    if (h >= FULL_TURN_OUT) h = h - FULL_TURN_OUT;
    return h[HW-1:0];
  endfunction

  function automatic void add_pair(logic signed [W-1:0] x, logic signed [W-1:0] y);
    field_pair_t p;
    p.x = x;
    p.y = y;
    pending_pairs.push_back(p);
  endfunction

  function automatic logic signed [W-1:0] small_val();
    int v;
    v = int'($urandom_range(0, 16)) - 8;
    return W'(v);
  endfunction

  function automatic logic signed [W-1:0] edge_val();
    case ($urandom_range(0, 4))
      0:       return F_MIN;
      1:       return F_MAX;
      2:       return '1;
      3:       return '0;
      default: return W'(1);
    endcase
  endfunction

  // Request driver: holds a request until it is taken, idles in bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        headings_due.push_back(heading_of(field_x, field_y));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 150 && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          field_x  <= pending_pairs[0].x;
          field_y  <= pending_pairs[0].y;
          in_valid <= 1'b1;
          pending_pairs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the pipeline fills and backs up its input.
  always @(posedge clk_i) begin
    if (rst_ni && !hold_done) begin
      if (!hold_on && n_sent >= 300) begin
        hold_on  <= 1'b1;
        hold_cnt <= 0;
      end else if (hold_on) begin
        if (hold_cnt == 250) begin
          hold_on   <= 1'b0;
          hold_done <= 1'b1;
        end else begin
          hold_cnt <= hold_cnt + 1;
        end
      end
    end
  end

  // Result monitor and checker; also drives the result-side ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (headings_due.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10)
            $display("unexpected result: heading=%0d", heading_o);
        end else begin
          if (heading_o !== headings_due[0]) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10)
              $display("heading mismatch: expected=%0d actual=%0d",
                       headings_due[0], heading_o);
          end
          headings_due.pop_front();
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (pending_pairs.size() > 150 && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 10);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= !hold_on;
      end
    end
  end

  initial begin
    // Zero vector, axes and extremes.
    add_pair('0, '0);
    add_pair(W'(1), '0);
    add_pair('0, W'(1));
    add_pair('1, '0);
    add_pair('0, '1);
    add_pair(F_MAX, '0);
    add_pair(F_MIN, '0);
    add_pair('0, F_MAX);
    add_pair('0, F_MIN);
    add_pair(F_MAX, F_MAX);
    add_pair(F_MIN, F_MIN);
    add_pair(F_MAX, F_MIN);
    add_pair(F_MIN, F_MAX);
    add_pair('1, '1);
    add_pair(W'(1), '1);
    add_pair('1, W'(1));
    // Just below the positive x axis, where the heading rounds to a full turn, and other pairs close to an axis.
    add_pair(F_MAX, '1);
    add_pair(F_MAX, W'(-2));
    add_pair(F_MIN, '1);
    add_pair(F_MIN, W'(1));
    add_pair(F_MAX, W'(1));
    add_pair(W'(1), F_MIN);
    add_pair(F_MIN, W'(-3));
    for (int n = 0; n < N_RAND; n++) begin
      case ($urandom_range(0, 9))
        5:       add_pair(small_val(), small_val());
        6:       add_pair(W'($urandom), small_val());
        7:       add_pair(small_val(), W'($urandom));
        8: begin
          field_pair_t d;
          d.x = W'($urandom_range(0, 131071));
          d.y = $urandom_range(0, 1) ? d.x : -d.x;
          if ($urandom_range(0, 1)) d.x = -d.x;
          add_pair(d.x, d.y);
        end
        9:       add_pair(edge_val(), edge_val());
        default: add_pair(W'($urandom), W'($urandom));
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid) @(posedge clk_i);
    while (headings_due.size() != 0) @(posedge clk_i);
    repeat (STAGES + 20) @(posedge clk_i);
    if (n_errors == 0 && headings_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
